>>> src/ffpa_pkg.sv
package ffpa_pkg;

	// Operation codes carried in the func field of a request.
	localparam logic [1:0] FUNC_ALLOC    = 2'd0;
	localparam logic [1:0] FUNC_ALLOC_AT = 2'd1;
	localparam logic [1:0] FUNC_FREE     = 2'd2;

	// Width of the page count register and of a stored run length.
	localparam int CFG_W = 11;
	localparam int RUN_W = 11;

	// Page count after reset.
	localparam logic [CFG_W-1:0] PAGES_RESET = 11'd1024;

	// Result address of a failed allocation.
	localparam logic [31:0] FAIL_ADDR = 32'hFFFF_FFFF;

	// Request beat.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] byte_count;
		logic [31:0] address;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [31:0] result_address;
		logic        ok;
	} rsp_t;

endpackage

>>> src/ffpa_ram.sv
module ffpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/first_fit_page_allocator.sv
// Channel   Direction  Handshake              Beat
// req       in         req_valid / req_ready  ffpa_pkg::req_t (func, byte_count, address)
// rsp       out        rsp_valid / rsp_ready  ffpa_pkg::rsp_t (result_address, ok)
// cfg       in         cfg_we                 cfg_wdata, page count register
//
// After reset the block clears both page memories, one page per cycle, through all MAX_PAGES
// pages; req_ready stays low during that pass, while cfg writes are taken as usual.
// An allocate reads one page per cycle from the used and run-length memories, dropping
// the read in flight at each skipped allocation, then writes one used bit per claimed page.
// An allocate-at reads its pages in the same way before it claims them, a free reads and
// clears the stored run length and then clears one used bit per released page, and a
// request that fails its range checks goes straight to the response.
// One request is in work at a time; the response register lets a new request be
// accepted while the previous response still waits for rsp_ready.
module first_fit_page_allocator
	import ffpa_pkg::*;
#(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int PG_W   = $clog2(MAX_PAGES);
	localparam int OFS_W  = $clog2(PAGE_BYTES);
	localparam int SCAN_W = ((PG_W > RUN_W) ? PG_W : RUN_W) + 1;
	localparam int NEED_W = 33 - OFS_W;
	localparam int PGF_W  = 32 - OFS_W;
	localparam int CMP_W  = 34;

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_FREE_RD = 4'd4;
	localparam logic [3:0] S_FREE_EV = 4'd5;
	localparam logic [3:0] S_CLAIM   = 4'd6;
	localparam logic [3:0] S_RELEASE = 4'd7;
	localparam logic [3:0] S_RESP    = 4'd8;

	logic [3:0]        state_q;
	logic [PG_W-1:0]   clr_q;
	logic [CFG_W-1:0]  pages_in_use_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	rsp_t              res_q;
	logic [RUN_W-1:0]  need_q;
	logic [PG_W-1:0]   base_q;
	logic [SCAN_W-1:0] rd_pc_q;
	logic              valid_s1;
	logic [SCAN_W-1:0] pc_s1;
	logic [RUN_W-1:0]  run_q;
	logic [PG_W-1:0]   wr_pc_q;
	logic [RUN_W-1:0]  left_q;
	logic              first_q;

	logic              used_we;
	logic [PG_W-1:0]   used_waddr;
	logic              used_wdata;
	logic              used_rdata;
	logic              rl_we;
	logic [PG_W-1:0]   rl_waddr;
	logic [RUN_W-1:0]  rl_wdata;
	logic [RUN_W-1:0]  rl_rdata;
	logic [PG_W-1:0]   mem_raddr;

	logic [SCAN_W-1:0] limit;
	logic [NEED_W-1:0] need_full;
	logic [PGF_W-1:0]  page_full;
	logic              aligned;
	logic              alloc_bad;
	logic              at_bad;
	logic              free_bad;
	logic              run_hit;
	logic [SCAN_W-1:0] start_w;
	logic [63:0]       start_ofs;
	logic [SCAN_W-1:0] rel_sum;
	logic [SCAN_W-1:0] rel_end;
	logic              rsp_load;

	// Effective page count and request decode.
	always_comb begin
		if (SCAN_W'(pages_in_use_q) < SCAN_W'(MAX_PAGES)) begin
			limit = SCAN_W'(pages_in_use_q);
		end else begin
			limit = SCAN_W'(MAX_PAGES);
		end
		need_full = NEED_W'(req.byte_count[31:OFS_W])
			+ NEED_W'(|req.byte_count[OFS_W-1:0]);
		page_full = req.address[31:OFS_W];
		aligned   = (req.address[OFS_W-1:0] == '0);
		alloc_bad = (need_full == '0) || (CMP_W'(need_full) > CMP_W'(limit));
		at_bad    = !aligned || (need_full == '0)
			|| (CMP_W'(page_full) + CMP_W'(need_full) > CMP_W'(limit));
		free_bad  = !aligned || (CMP_W'(page_full) >= CMP_W'(MAX_PAGES));
	end

	// Window tracking for the scan and the allocate-at check.
	always_comb begin
		run_hit   = ((RUN_W + 1)'(run_q) + (RUN_W + 1)'(1)) == (RUN_W + 1)'(need_q);
		start_w   = pc_s1 + SCAN_W'(1) - SCAN_W'(need_q);
		start_ofs = 64'(start_w[PG_W-1:0]) << OFS_W;
		rel_sum   = SCAN_W'(base_q) + SCAN_W'(rl_rdata);
		if (rel_sum > SCAN_W'(MAX_PAGES)) begin
			rel_end = SCAN_W'(MAX_PAGES);
		end else begin
			rel_end = rel_sum;
		end
	end

	// Memory ports.
	always_comb begin
		used_we    = (state_q == S_CLR) || (state_q == S_CLAIM) || (state_q == S_RELEASE);
		used_waddr = (state_q == S_CLR) ? clr_q : wr_pc_q;
		used_wdata = (state_q == S_CLAIM);
		rl_we      = (state_q == S_CLR) || ((state_q == S_CLAIM) && first_q)
			|| ((state_q == S_FREE_EV) && (rl_rdata != '0));
		rl_waddr   = (state_q == S_CLR) ? clr_q : base_q;
		rl_wdata   = (state_q == S_CLAIM) ? need_q : '0;
		mem_raddr  = (state_q == S_FREE_RD) ? base_q : rd_pc_q[PG_W-1:0];
	end

	ffpa_ram #(
		.WIDTH (1),
		.DEPTH (MAX_PAGES)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (mem_raddr),
		.rdata (used_rdata)
	);

	ffpa_ram #(
		.WIDTH (RUN_W),
		.DEPTH (MAX_PAGES)
	) u_run_ram (
		.clk   (clk),
		.we    (rl_we),
		.waddr (rl_waddr),
		.wdata (rl_wdata),
		.raddr (mem_raddr),
		.rdata (rl_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q <= PAGES_RESET;
		end else if (cfg_we) begin
			pages_in_use_q <= cfg_wdata;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res_q;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Sequencer: clear, decode, scan, check, claim and release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			res_q    <= '0;
			need_q   <= '0;
			base_q   <= '0;
			rd_pc_q  <= '0;
			valid_s1 <= 1'b0;
			pc_s1    <= '0;
			run_q    <= '0;
			wr_pc_q  <= '0;
			left_q   <= '0;
			first_q  <= 1'b0;
		end else begin
			pc_s1 <= rd_pc_q;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PG_W'(1);
					if (clr_q == PG_W'(MAX_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						res_q.result_address <= FAIL_ADDR;
						res_q.ok             <= 1'b0;
						need_q   <= RUN_W'(need_full);
						base_q   <= PG_W'(page_full);
						valid_s1 <= 1'b0;
						run_q    <= '0;
						state_q  <= S_RESP;
						case (req.func)
							FUNC_ALLOC: begin
								rd_pc_q <= '0;
								if (!alloc_bad) begin
									state_q <= S_SCAN;
								end
							end
							FUNC_ALLOC_AT: begin
								rd_pc_q <= SCAN_W'(page_full);
								if (!at_bad) begin
									state_q <= S_CHECK;
								end
							end
							FUNC_FREE: begin
								res_q.result_address <= '0;
								if (!free_bad) begin
									state_q <= S_FREE_RD;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_pc_q  <= rd_pc_q + SCAN_W'(1);
					valid_s1 <= 1'b1;
					if (valid_s1) begin
						if (pc_s1 >= limit) begin
							state_q <= S_RESP;
						end else if (!used_rdata) begin
							run_q <= run_q + RUN_W'(1);
							if (run_hit) begin
								base_q         <= start_w[PG_W-1:0];
								wr_pc_q        <= start_w[PG_W-1:0];
								left_q         <= need_q;
								first_q        <= 1'b1;
								res_q.result_address <= start_ofs[31:0];
								res_q.ok       <= 1'b1;
								state_q        <= S_CLAIM;
							end
						end else if (rl_rdata != '0) begin
							// Jump over a known allocation; the read in flight is dropped.
							run_q    <= '0;
							rd_pc_q  <= pc_s1 + SCAN_W'(rl_rdata);
							valid_s1 <= 1'b0;
						end else begin
							run_q <= '0;
						end
					end
				end
				S_CHECK: begin
					rd_pc_q  <= rd_pc_q + SCAN_W'(1);
					valid_s1 <= 1'b1;
					if (valid_s1) begin
						if (used_rdata) begin
							state_q <= S_RESP;
						end else begin
							run_q <= run_q + RUN_W'(1);
							if (run_hit) begin
								wr_pc_q        <= start_w[PG_W-1:0];
								left_q         <= need_q;
								first_q        <= 1'b1;
								res_q.result_address <= start_ofs[31:0];
								res_q.ok       <= 1'b1;
								state_q        <= S_CLAIM;
							end
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_EV;
				end
				S_FREE_EV: begin
					if (rl_rdata == '0) begin
						state_q <= S_RESP;
					end else begin
						wr_pc_q  <= base_q;
						left_q   <= RUN_W'(rel_end - SCAN_W'(base_q));
						res_q.ok <= 1'b1;
						state_q  <= S_RELEASE;
					end
				end
				S_CLAIM: begin
					first_q <= 1'b0;
					wr_pc_q <= wr_pc_q + PG_W'(1);
					left_q  <= left_q - RUN_W'(1);
					if (left_q == RUN_W'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RELEASE: begin
					wr_pc_q <= wr_pc_q + PG_W'(1);
					left_q  <= left_q - RUN_W'(1);
					if (left_q == RUN_W'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The memories are never written while the block waits for a request.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(used_we || rl_we))
		else $error("page memory written while idle");

	// A claim or release pass always has pages left to write.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CLAIM) || (state_q == S_RELEASE)) |-> (left_q != '0))
		else $error("claim or release pass with no pages left");

	// Every page write stays inside the managed memory.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_we |-> ((SCAN_W'(used_waddr) < SCAN_W'(MAX_PAGES))))
		else $error("used bit written beyond the last page");

	// A claim only starts after a free window of the requested size was seen.
	a_claim_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CLAIM) && first_q) |-> $past(valid_s1 && !used_rdata && run_hit))
		else $error("claim started without a free window");

endmodule
